FILE: rtl/keyword_occurrence_counter_top_assert.svh
// ---------------------------------------------------------------------------
// Keyword occurrence counter: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef KEYWORD_OCCURRENCE_COUNTER_TOP_ASSERT_SVH
`define KEYWORD_OCCURRENCE_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define KOCNT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kocnt check failed");

// Next-cycle implication, sampled on clk, off during reset
`define KOCNT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kocnt check failed");

`endif

FILE: rtl/kocnt_pkg.sv
// ---------------------------------------------------------------------------
// Keyword occurrence counter package
// Shared constants for the keyword cell chain and its control.
// ---------------------------------------------------------------------------
package kocnt_pkg;

	// Keyword storage and limits
	localparam int MAX_KEY_BYTES_DEF = 16;
	localparam int KEY_STORE_BYTES   = 16;
	localparam int BYTE_W            = 8;
	localparam int CFG_DATA_W        = 64;
	localparam int KEY_LEN_W         = 5;
	localparam int COUNT_W           = 32;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

	// Special byte values
	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [BYTE_W-1:0] NUL_BYTE     = 8'h00;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd1;

endpackage

FILE: rtl/keyword_occurrence_counter_top.sv
// ---------------------------------------------------------------------------
// Keyword occurrence counter
// Counts leftmost non-overlapping keyword hits per line over a byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries data_byte, has_byte and
//   end_of_file. One transaction is taken per cycle while in_stall is low; the window is a chain
//   of byte cells, each comparing in parallel, so a match is resolved in the
//   same cycle its last byte arrives.
//   Output channel (out_valid / out_stall) carries match_count, one
//   transaction per input transaction with end_of_file set. The count is
//   registered in the output register, or parked in the skid register while that one still waits.
//   Throughput: 1 byte per cycle while in_stall is low, bounded by the span/hit feedback loop.
//   A result waiting in the output register does not block input; a second
//   result parks in a skid register, and input is stalled only while that
//   skid register is full, until the receiver takes the waiting result.
//   Configuration: cfg_wen writes register cfg_index (0 key bytes 0-7,
//   1 key bytes 8-15, 2 key length); the user must write only while the block is idle, which it does not enforce.
//   Reset: clears the count, line state, output valid and the key registers
//   (length 1, key bytes zero). No clearing pass is needed.
// ---------------------------------------------------------------------------
module keyword_occurrence_counter_top #(
	parameter int MAX_KEY_BYTES = kocnt_pkg::MAX_KEY_BYTES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_wen,
	input  logic [kocnt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kocnt_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [kocnt_pkg::BYTE_W-1:0]         data_byte,
	input  logic                                 has_byte,
	input  logic                                 end_of_file,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [kocnt_pkg::COUNT_W-1:0]        match_count
);

	localparam int LW = $clog2(MAX_KEY_BYTES + 1);
	localparam logic [LW-1:0] SPAN_MAX = LW'(MAX_KEY_BYTES);

	logic [kocnt_pkg::CFG_DATA_W-1:0] key_low_q;
	logic [kocnt_pkg::CFG_DATA_W-1:0] key_high_q;
	logic [kocnt_pkg::KEY_LEN_W-1:0]  key_length_q;

	logic [kocnt_pkg::BYTE_W-1:0] key_byte [kocnt_pkg::KEY_STORE_BYTES];
	logic [kocnt_pkg::KEY_LEN_W-1:0] clamp_len;
	logic [LW-1:0] eff_len;

	logic [LW-1:0] span_q;
	logic [LW-1:0] span_inc;
	logic          blocked_q;
	logic [kocnt_pkg::COUNT_W-1:0] count_q;
	logic [kocnt_pkg::COUNT_W-1:0] count_next;
	logic          out_valid_q;
	logic [kocnt_pkg::COUNT_W-1:0] match_count_q;
	logic          skid_valid_q;
	logic [kocnt_pkg::COUNT_W-1:0] skid_count_q;

	logic accept;
	logic take;
	logic hit;
	logic out_fire;

	logic [kocnt_pkg::BYTE_W-1:0] cell_din      [MAX_KEY_BYTES];
	logic [kocnt_pkg::BYTE_W-1:0] cell_dout     [MAX_KEY_BYTES];
	logic [kocnt_pkg::BYTE_W-1:0] cell_expected [MAX_KEY_BYTES];
	logic [MAX_KEY_BYTES-1:0]     cell_eq;
	logic [MAX_KEY_BYTES-1:0]     cell_used;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q    <= '0;
			key_high_q   <= '0;
			key_length_q <= kocnt_pkg::KEY_LEN_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				kocnt_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data;
				kocnt_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data;
				kocnt_pkg::CFG_KEY_LEN:
					key_length_q <= cfg_data[kocnt_pkg::KEY_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Key bytes unpacked from the two key words
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			key_byte[i]     = key_low_q[8*i +: 8];
			key_byte[i + 8] = key_high_q[8*i +: 8];
		end
	end

	// Effective length: clamp, then cut at the first zero key byte
	always_comb begin
		clamp_len = key_length_q;
		if (clamp_len == '0) begin
			clamp_len = 5'd1;
		end
		if (clamp_len > kocnt_pkg::KEY_LEN_W'(MAX_KEY_BYTES)) begin
			clamp_len = kocnt_pkg::KEY_LEN_W'(MAX_KEY_BYTES);
		end
		eff_len = LW'(clamp_len);
		for (int i = MAX_KEY_BYTES - 1; i >= 0; i--) begin
			if ((kocnt_pkg::KEY_LEN_W'(i) < clamp_len) && (key_byte[i] == kocnt_pkg::NUL_BYTE)) begin
				eff_len = LW'(i);
			end
		end
	end

	// Per-cell keyword byte: cell i compares the byte i places back, so it
	// faces key byte (len - 1 - i)
	always_comb begin
		for (int i = 0; i < MAX_KEY_BYTES; i++) begin
			cell_expected[i] = kocnt_pkg::NUL_BYTE;
			cell_used[i]     = (LW'(i) < eff_len);
			for (int j = 0; j < MAX_KEY_BYTES; j++) begin
				if ((i + j + 1) == int'(eff_len)) begin
					cell_expected[i] = key_byte[j];
				end
			end
		end
	end

	// Handshake and byte qualification
	assign in_stall = skid_valid_q;
	assign accept   = in_valid & ~in_stall;
	assign out_fire = out_valid_q & ~out_stall;
	assign take     = accept & has_byte & ~blocked_q & (data_byte != kocnt_pkg::NUL_BYTE);

	// Cell chain
	always_comb begin
		cell_din[0] = data_byte;
		for (int i = 1; i < MAX_KEY_BYTES; i++) begin
			cell_din[i] = cell_dout[i - 1];
		end
	end

	for (genvar g = 0; g < MAX_KEY_BYTES; g++) begin : g_cell
		kocnt_cell u_cell (
			.clk      (clk),
			.shift    (take),
			.din      (cell_din[g]),
			.expected (cell_expected[g]),
			.dout     (cell_dout[g]),
			.eq       (cell_eq[g])
		);
	end

	// Match decision
	assign span_inc = (span_q == SPAN_MAX) ? span_q : span_q + 1'b1;
	assign hit = take && (eff_len != '0) && (span_inc >= eff_len) && (&(cell_eq | ~cell_used));
	assign count_next = (hit && (count_q != kocnt_pkg::COUNT_MAX)) ? count_q + 1'b1 : count_q;

	// Line state, span and running count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q    <= '0;
			blocked_q <= 1'b0;
			count_q   <= '0;
		end else if (accept) begin
			if (end_of_file) begin
				span_q    <= '0;
				blocked_q <= 1'b0;
				count_q   <= '0;
			end else begin
				count_q <= count_next;
				if (has_byte) begin
					if (blocked_q) begin
						if (data_byte == kocnt_pkg::NEWLINE_BYTE) begin
							blocked_q <= 1'b0;
						end
					end else if (data_byte == kocnt_pkg::NUL_BYTE) begin
						blocked_q <= 1'b1;
						span_q    <= '0;
					end else if (hit || (data_byte == kocnt_pkg::NEWLINE_BYTE)) begin
						span_q <= '0;
					end else begin
						span_q <= span_inc;
					end
				end
			end
		end
	end

	// Output register with a skid slot behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept && end_of_file) begin
			if (out_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				match_count_q <= skid_count_q;
			end
		end else if (accept && end_of_file) begin
			if (out_valid_q && !out_fire) begin
				skid_count_q <= count_next;
			end else begin
				match_count_q <= count_next;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign match_count = match_count_q;

	// Checks
`include "keyword_occurrence_counter_top_assert.svh"

	`KOCNT_ASSERT_NOW(a_blocked_no_span, blocked_q, span_q == '0)
	`KOCNT_ASSERT_NOW(a_span_capped, 1'b1, span_q <= SPAN_MAX)
	`KOCNT_ASSERT_NEXT(a_eof_clears, accept && end_of_file, out_valid_q && (count_q == '0) && !blocked_q)
	`KOCNT_ASSERT_NOW(a_rise_from_eof, $rose(out_valid_q), $past(accept && end_of_file))
	`KOCNT_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)

endmodule

FILE: rtl/kocnt_cell.sv
// ---------------------------------------------------------------------------
// Keyword occurrence counter: window cell
// Holds one byte of the recent-byte window, shifts it on to the next cell
// and compares the byte it is about to take against its keyword byte.
// ---------------------------------------------------------------------------
module kocnt_cell (
	input  logic                           clk,
	input  logic                           shift,
	input  logic [kocnt_pkg::BYTE_W-1:0]   din,
	input  logic [kocnt_pkg::BYTE_W-1:0]   expected,
	output logic [kocnt_pkg::BYTE_W-1:0]   dout,
	output logic                           eq
);

	logic [kocnt_pkg::BYTE_W-1:0] byte_q;

	// Window byte, advanced only when a byte enters the window
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= din;
		end
	end

	// Compare the incoming byte, which is this cell's byte after the shift
	assign eq   = (din == expected);
	assign dout = byte_q;

endmodule
